@@ design/keypad_code_lock_barrier_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keypad code lock barrier controller
// Shared forms for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_BARRIER_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_BARRIER_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define KCLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kclb_pkg.sv @@
// ----------------------------------------------------------------------------
// kclb_pkg
// Types, codes and key layout for the keypad code lock barrier controller.
// ----------------------------------------------------------------------------
package kclb_pkg;

  localparam int CODE_DIGITS_DEF = 6;

  localparam int CODE_W   = 20;
  localparam int HOLD_W   = 16;
  localparam int RADIUS_W = 6;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [CODE_W-1:0]   UNLOCK_CODE_RST = 20'd123456;
  localparam logic [HOLD_W-1:0]   HOLD_MS_RST     = 16'd3000;
  localparam logic [RADIUS_W-1:0] KEY_RADIUS_RST  = 6'd50;

  // register indexes (word address)
  localparam logic [1:0] REG_UNLOCK_CODE = 2'd0;
  localparam logic [1:0] REG_HOLD_MS     = 2'd1;
  localparam logic [1:0] REG_KEY_RADIUS  = 2'd2;

  // key codes
  localparam logic [3:0] KEY_CLEAR = 4'd10;
  localparam logic [3:0] KEY_ENTER = 4'd11;
  localparam logic [3:0] KEY_NONE  = 4'd12;

  // entry status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_DIGIT   = 3'd1;
  localparam logic [2:0] ST_CODE_OK = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // ramp command codes
  localparam logic [1:0] RAMP_NONE  = 2'd0;
  localparam logic [1:0] RAMP_OPEN  = 2'd1;
  localparam logic [1:0] RAMP_CLOSE = 2'd2;

  // digit keys in priority order 1 4 7 2 5 8 3 6 9 0
  localparam logic [9:0] DIGIT_X [10] = '{10'd120, 10'd120, 10'd120, 10'd240, 10'd240,
                                          10'd240, 10'd360, 10'd360, 10'd360, 10'd240};
  localparam logic [9:0] DIGIT_Y [10] = '{10'd374, 10'd480, 10'd586, 10'd374, 10'd480,
                                          10'd586, 10'd374, 10'd480, 10'd586, 10'd692};
  localparam logic [3:0] DIGIT_V [10] = '{4'd1, 4'd4, 4'd7, 4'd2, 4'd5,
                                          4'd8, 4'd3, 4'd6, 4'd9, 4'd0};

  localparam logic [9:0] ENTER_X = 10'd360;
  localparam logic [9:0] CLEAR_X = 10'd120;
  localparam logic [9:0] FUNC_Y  = 10'd692;

  typedef struct packed {
    logic [CODE_W-1:0]   unlock_code;
    logic [HOLD_W-1:0]   hold_ms;
    logic [RADIUS_W-1:0] key_radius;
  } cfg_t;

  typedef struct packed {
    logic       digit_found;
    logic [3:0] digit_val;
    logic       enter_hit;
    logic       clear_hit;
  } key_hit_t;

  // strict box test on both axes
  function automatic logic in_box(logic [9:0] x, logic [9:0] y, logic [9:0] cx,
                                  logic [9:0] cy, logic [RADIUS_W-1:0] r);
    logic [9:0] dx;
    logic [9:0] dy;
    dx = (x > cx) ? x - cx : cx - x;
    dy = (y > cy) ? y - cy : cy - y;
    return (dx < 10'(r)) && (dy < 10'(r));
  endfunction

endpackage

@@ design/keypad_code_lock_barrier_controller.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_barrier_controller
// Touch keypad code lock driving an access barrier.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side keeps up, and returns
// exactly one result per item. An accepted item is held in the input
// register, where the key hit test and the lock and barrier update run, and
// its result is registered when the item advances into the result register.
// A stalled result holds the input register, so at most two items are in
// flight. Lock state (digit buffer, open request, barrier state, elapsed
// count) is committed when the item moves into the result register.
// digits_held and barrier_open show the state left by the item in the
// result register.
// Configuration through the APB port: unlock_code at 0x0, hold_ms at 0x4,
// key_radius at 0x8.
module keypad_code_lock_barrier_controller import kclb_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [8:0]        touch_x_i,
  input  logic [9:0]        touch_y_i,
  input  logic              vehicle_sensor_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        key_hit_o,
  output logic [2:0]        entry_status_o,
  output logic [1:0]        ramp_command_o,
  output logic [2:0]        digits_held_o,
  output logic              barrier_open_o
);

  cfg_t       cfg;
  key_hit_t   hit;
  logic [8:0] s1_x;
  logic [9:0] s1_y;

  kclb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kclb_keypad u_keypad (
    .touch_x_i (s1_x),
    .touch_y_i (s1_y),
    .radius_i  (cfg.key_radius),
    .hit_o     (hit)
  );

  kclb_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .touch_x_i        (touch_x_i),
    .touch_y_i        (touch_y_i),
    .vehicle_sensor_i (vehicle_sensor_i),
    .s1_x_o           (s1_x),
    .s1_y_o           (s1_y),
    .hit_i            (hit),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_hit_o        (key_hit_o),
    .entry_status_o   (entry_status_o),
    .ramp_command_o   (ramp_command_o),
    .digits_held_o    (digits_held_o),
    .barrier_open_o   (barrier_open_o)
  );

endmodule

@@ design/kclb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// kclb_cfg_regs
// APB-style configuration registers: unlock code, hold time, key radius.
// ----------------------------------------------------------------------------
module kclb_cfg_regs import kclb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_UNLOCK_CODE: cfg_d.unlock_code = pwdata[CODE_W-1:0];
        REG_HOLD_MS:     cfg_d.hold_ms     = pwdata[HOLD_W-1:0];
        REG_KEY_RADIUS:  cfg_d.key_radius  = pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_UNLOCK_CODE: prdata = DATA_W'(cfg_q.unlock_code);
      REG_HOLD_MS:     prdata = DATA_W'(cfg_q.hold_ms);
      REG_KEY_RADIUS:  prdata = DATA_W'(cfg_q.key_radius);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unlock_code <= UNLOCK_CODE_RST;
      cfg_q.hold_ms     <= HOLD_MS_RST;
      cfg_q.key_radius  <= KEY_RADIUS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/kclb_keypad.sv @@
// ----------------------------------------------------------------------------
// kclb_keypad
// Hit test of a touch position against the 3-by-4 key grid.
// ----------------------------------------------------------------------------
module kclb_keypad import kclb_pkg::*; (
  input  logic [8:0]          touch_x_i,
  input  logic [9:0]          touch_y_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output key_hit_t            hit_o
);

  logic [9:0] x_ext;

  assign x_ext = {1'b0, touch_x_i};

  always_comb begin
    hit_o.digit_found = 1'b0;
    hit_o.digit_val   = 4'd0;
    // walk backwards so the first key in priority order wins
    for (int i = 9; i >= 0; i--) begin
      if (in_box(x_ext, touch_y_i, DIGIT_X[i], DIGIT_Y[i], radius_i)) begin
        hit_o.digit_found = 1'b1;
        hit_o.digit_val   = DIGIT_V[i];
      end
    end
    hit_o.enter_hit = in_box(x_ext, touch_y_i, ENTER_X, FUNC_Y, radius_i);
    hit_o.clear_hit = in_box(x_ext, touch_y_i, CLEAR_X, FUNC_Y, radius_i);
  end

endmodule

@@ design/kclb_core.sv @@
// ----------------------------------------------------------------------------
// kclb_core
// Input register, lock and barrier state update, result register.
// ----------------------------------------------------------------------------
module kclb_core import kclb_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [8:0] touch_x_i,
  input  logic [9:0] touch_y_i,
  input  logic       vehicle_sensor_i,
  output logic [8:0] s1_x_o,
  output logic [9:0] s1_y_o,
  input  key_hit_t   hit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] key_hit_o,
  output logic [2:0] entry_status_o,
  output logic [1:0] ramp_command_o,
  output logic [2:0] digits_held_o,
  output logic       barrier_open_o
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int NUM_W = $clog2(10 ** CODE_DIGITS);

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic       s1_func_q;
  logic [8:0] s1_x_q;
  logic [9:0] s1_y_q;
  logic       s1_sensor_q;
  logic       accept, advance;

  // lock state
  logic [3:0]       store_q [CODE_DIGITS];
  logic [3:0]       store_d [CODE_DIGITS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic             open_q, open_d;
  logic [HOLD_W-1:0] ms_q, ms_d;

  // result stage
  logic       out_valid_q, out_valid_d;
  logic [3:0] key_q, key_d;
  logic [2:0] status_q, status_d;
  logic [1:0] ramp_q, ramp_d;

  logic [NUM_W-1:0] num;
  logic             code_match;

  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign accept     = in_valid_i & in_ready_o;

  assign s1_valid_d  = accept | (s1_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);

  assign s1_x_o = s1_x_q;
  assign s1_y_o = s1_y_q;

  // number built from all positions, most significant first
  always_comb begin
    num = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      num = NUM_W'((num << 3) + (num << 1) + NUM_W'(store_q[i]));
    end
  end

  assign code_match = (32'(num) == 32'(cfg_i.unlock_code));

  always_comb begin
    store_d  = store_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    open_d   = open_q;
    ms_d     = ms_q;
    key_d    = KEY_NONE;
    status_d = ST_NONE;
    ramp_d   = RAMP_NONE;

    if (!s1_func_q && open_q && (ms_q != '1)) begin
      ms_d = ms_q + 1'b1;
    end

    // close takes precedence over open
    if (s1_sensor_q && open_q && (ms_d > cfg_i.hold_ms)) begin
      open_d = 1'b0;
      ramp_d = RAMP_CLOSE;
    end else if (pend_q && !s1_sensor_q && !open_q) begin
      open_d = 1'b1;
      ms_d   = '0;
      pend_d = 1'b0;
      ramp_d = RAMP_OPEN;
    end

    if (s1_func_q) begin
      if (hit_i.digit_found && (cnt_q < CNT_W'(CODE_DIGITS))) begin
        key_d                  = hit_i.digit_val;
        store_d[cnt_q[IDX_W-1:0]] = hit_i.digit_val;
        cnt_d                  = cnt_q + 1'b1;
        status_d               = ST_DIGIT;
      end else if (hit_i.enter_hit) begin
        key_d = KEY_ENTER;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          store_d[i] = 4'd0;
        end
        cnt_d    = '0;
        pend_d   = code_match;
        status_d = code_match ? ST_CODE_OK : ST_INVALID;
      end else if (hit_i.clear_hit) begin
        key_d = KEY_CLEAR;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          store_d[i] = 4'd0;
        end
        cnt_d    = '0;
        pend_d   = 1'b0;
        status_d = ST_CLEARED;
      end else if (hit_i.digit_found) begin
        // buffer full: report the key, drop the digit
        key_d = hit_i.digit_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      open_q      <= 1'b0;
      ms_q        <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        store_q[i] <= 4'd0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        store_q <= store_d;
        cnt_q   <= cnt_d;
        pend_q  <= pend_d;
        open_q  <= open_d;
        ms_q    <= ms_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_i;
      s1_x_q      <= touch_x_i;
      s1_y_q      <= touch_y_i;
      s1_sensor_q <= vehicle_sensor_i;
    end
    if (advance) begin
      key_q    <= key_d;
      status_q <= status_d;
      ramp_q   <= ramp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_hit_o      = key_q;
  assign entry_status_o = status_q;
  assign ramp_command_o = ramp_q;
  assign digits_held_o  = 3'(cnt_q);
  assign barrier_open_o = open_q;

endmodule

@@ design/kclb_checker.sv @@
// ----------------------------------------------------------------------------
// kclb_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_barrier_controller_assert.svh"

module kclb_checker import kclb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] key_hit_o,
  input logic [2:0] entry_status_o,
  input logic [1:0] ramp_command_o,
  input logic [2:0] digits_held_o,
  input logic       barrier_open_o
);

  // a stalled item keeps its key code
  `KCLB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(key_hit_o), "stalled item changed")

  // a buffered digit is reported with a digit key
  `KCLB_ASSERT_NOW(a_digit_key, clk_i, rst_ni, out_valid_o && (entry_status_o == ST_DIGIT), (key_hit_o < KEY_CLEAR) && (digits_held_o != 3'd0), "digit status without digit key")

  // ramp command agrees with barrier state
  `KCLB_ASSERT_NOW(a_ramp_state, clk_i, rst_ni, out_valid_o && (ramp_command_o != RAMP_NONE), barrier_open_o == (ramp_command_o == RAMP_OPEN), "ramp command disagrees with barrier")

  // enter and clear leave the buffer empty
  `KCLB_ASSERT_NOW(a_buf_empty, clk_i, rst_ni, out_valid_o && ((entry_status_o == ST_CODE_OK) || (entry_status_o == ST_INVALID) || (entry_status_o == ST_CLEARED)), digits_held_o == 3'd0, "buffer not emptied")

endmodule

bind keypad_code_lock_barrier_controller kclb_checker u_kclb_checker (.*);
